@@ sv/mpeg_pack_header_parser_top_assert.svh @@
// Assertion macros used by the checker file of the pack header parser.
`ifndef MPEG_PACK_HEADER_PARSER_TOP_ASSERT_SVH
`define MPEG_PACK_HEADER_PARSER_TOP_ASSERT_SVH

// Clocked assertion, disabled while reset is asserted (active low).
`define MPHP_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("mphp check failed");

// Implication form: antecedent holds -> consequent in the same cycle.
`define MPHP_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  `MPHP_ASSERT(lbl, clk, rst_n, (ante) |-> (cons))

`endif

@@ sv/mphp_pkg.sv @@
// Types, constants and helpers of the MPEG pack header parser.
package mphp_pkg;

  localparam int unsigned HdrBytes = 10;

  // Byte positions inside a pack header.
  localparam logic [3:0] PosStartLen  = 4'd4;
  localparam logic [3:0] PosM1Last    = 4'd11;
  localparam logic [3:0] PosM2Last    = 4'd13;
  localparam logic [3:0] PosStuffing  = 4'd14;

  localparam logic [1:0] SyntaxMpeg2  = 2'b01;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_start;
  } mphp_in_t;

  typedef struct packed {
    logic        is_mpeg2;
    logic [32:0] clock_ref_base;
    logic [8:0]  clock_ref_ext;
    logic [21:0] mux_rate;
    logic [2:0]  stuffing_count;
    logic        bad_start;
  } mphp_out_t;

  // Work item from front to back.
  typedef struct packed {
    logic [7:0] data_byte;
    logic [3:0] idx;      // header byte slot 0..9
    logic       capture;  // store data_byte into slot idx
    logic       emit;     // header complete, build a result
    logic       bad;      // start code mismatch result
    logic       mpeg2;
  } mphp_cmd_t;

  function automatic logic [7:0] start_code_byte(input logic [1:0] pos);
    logic [7:0] b;
    case (pos)
      2'd0:    b = 8'h00;
      2'd1:    b = 8'h00;
      2'd2:    b = 8'h01;
      default: b = 8'hBA;
    endcase
    return b;
  endfunction

endpackage

@@ sv/mphp_cmd_fifo.sv @@
// Two-entry queue of work items between the parser front and back.
module mphp_cmd_fifo
  import mphp_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      wr_en_i,
  input  mphp_cmd_t wr_data_i,
  output logic      full_o,
  input  logic      rd_en_i,
  output mphp_cmd_t rd_data_o,
  output logic      empty_o
);

  mphp_cmd_t  mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       do_wr, do_rd;

  assign full_o    = (count_q == 2'd2);
  assign empty_o   = (count_q == 2'd0);
  assign rd_data_o = mem_q[rd_ptr_q];

  assign do_wr = wr_en_i && !full_o;
  assign do_rd = rd_en_i && !empty_o;

  always_comb begin
    wr_ptr_d = do_wr ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_rd ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (do_wr && !do_rd) begin
      count_d = count_q + 2'd1;
    end else if (do_rd && !do_wr) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

@@ sv/mphp_front.sv @@
// Parser front: tracks header position and classifies bytes into work items (not every byte yields one).
module mphp_front
  import mphp_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      accept_i,
  input  mphp_in_t  in_data_i,
  output logic      cmd_push_o,
  output mphp_cmd_t cmd_o
);

  logic       act_q, act_d;
  logic [3:0] pos_q, pos_d;
  logic [2:0] stl_q, stl_d;
  logic       m2_q, m2_d;

  always_comb begin
    logic       act;
    logic [3:0] pos;
    logic [2:0] stl;
    logic       m2;
    logic [7:0] b;

    act = act_q;
    pos = pos_q;
    stl = stl_q;
    m2  = m2_q;
    b   = in_data_i.data_byte;

    cmd_o           = '0;
    cmd_o.data_byte = b;
    cmd_push_o      = 1'b0;

    if (accept_i) begin
      if (in_data_i.frame_start) begin
        act = 1'b1;
        pos = 4'd0;
        stl = 3'd0;
      end
      if (act) begin
        if (pos >= PosStuffing) begin
          stl = stl - 3'd1;
          if (stl == 3'd0) begin
            cmd_o.emit  = 1'b1;
            cmd_o.mpeg2 = m2;
            cmd_push_o  = 1'b1;
            act = 1'b0;
            pos = 4'd0;
          end
        end else if (pos < PosStartLen) begin
          if (b != start_code_byte(pos[1:0])) begin
            cmd_o.bad  = 1'b1;
            cmd_push_o = 1'b1;
            act = 1'b0;
            pos = 4'd0;
            stl = 3'd0;
          end else begin
            pos = pos + 4'd1;
          end
        end else begin
          cmd_o.capture = 1'b1;
          cmd_o.idx     = pos - PosStartLen;
          cmd_push_o    = 1'b1;
          if (pos == PosStartLen) begin
            m2 = (b[7:6] == SyntaxMpeg2);
          end
          cmd_o.mpeg2 = m2;
          if (!m2 && pos == PosM1Last) begin
            cmd_o.emit = 1'b1;
            act = 1'b0;
            pos = 4'd0;
            stl = 3'd0;
          end else if (m2 && pos == PosM2Last) begin
            stl = b[2:0];
            if (stl == 3'd0) begin
              cmd_o.emit = 1'b1;
              act = 1'b0;
              pos = 4'd0;
            end else begin
              pos = PosStuffing;
            end
          end else begin
            pos = pos + 4'd1;
          end
        end
      end
    end

    act_d = act;
    pos_d = pos;
    stl_d = stl;
    m2_d  = m2;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q <= 1'b0;
      pos_q <= 4'd0;
      stl_q <= 3'd0;
      m2_q  <= 1'b0;
    end else begin
      act_q <= act_d;
      pos_q <= pos_d;
      stl_q <= stl_d;
      m2_q  <= m2_d;
    end
  end

endmodule

@@ sv/mphp_back.sv @@
// Parser back: stores header bytes, assembles fields and holds the result register.
module mphp_back
  import mphp_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cmd_empty_i,
  input  mphp_cmd_t cmd_i,
  output logic      cmd_pop_o,
  input  logic      pop,
  output logic      empty,
  output mphp_out_t out_data_o
);

  logic [7:0]  hb_q [HdrBytes];
  logic        out_vld_q, out_vld_d;
  mphp_out_t   out_q;
  mphp_out_t   res;
  logic [79:0] hdr;
  logic        produces, slot_free, take;

  assign produces  = cmd_i.emit || cmd_i.bad;
  assign slot_free = !out_vld_q || pop;
  assign take      = !cmd_empty_i && (!produces || slot_free);
  assign cmd_pop_o = take;

  // Header view with the byte in flight bypassed into its slot, MSB first.
  always_comb begin
    for (int i = 0; i < HdrBytes; i++) begin
      hdr[79 - 8*i -: 8] = (cmd_i.capture && cmd_i.idx == 4'(i)) ? cmd_i.data_byte : hb_q[i];
    end
  end

  always_comb begin
    res = '0;
    if (cmd_i.bad) begin
      res.bad_start = 1'b1;
    end else if (cmd_i.mpeg2) begin
      res.is_mpeg2       = 1'b1;
      res.clock_ref_base = {hdr[77 -: 3], hdr[73 -: 15], hdr[57 -: 15]};
      res.clock_ref_ext  = hdr[41 -: 9];
      res.mux_rate       = hdr[31 -: 22];
      res.stuffing_count = hdr[2:0];
    end else begin
      res.clock_ref_base = {hdr[75 -: 3], hdr[71 -: 15], hdr[55 -: 15]};
      res.mux_rate       = hdr[38 -: 22];
    end
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (take && produces) begin
      out_vld_d = 1'b1;
    end else if (pop) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && produces) begin
      out_q <= res;
    end
    for (int i = 0; i < HdrBytes; i++) begin
      if (take && cmd_i.capture && cmd_i.idx == 4'(i)) begin
        hb_q[i] <= cmd_i.data_byte;
      end
    end
  end

  assign empty      = !out_vld_q;
  assign out_data_o = out_q;

endmodule

@@ sv/mpeg_pack_header_parser_top.sv @@
// Top level of the MPEG program stream pack header parser.
//
//  channel | handshake          | payload                 | accepted when
//  --------+--------------------+-------------------------+------------------
//  input   | push (i), full (o) | in_data_i  (mphp_in_t)  | push && !full
//  result  | pop (i), empty (o) | out_data_o (mphp_out_t) | pop && !empty
//
// One byte is taken every cycle while the work queue has room; full only
// rises when results back up behind an unread result register.
// A result goes through the work queue and then the result register.
// Reset (rst_ni low, async) clears parse position, queue and result valid;
// stored header bytes are not reset and are always rewritten before use.
// A stalled result holds steady until popped; stalls never drop bytes.
module mpeg_pack_header_parser_top
  import mphp_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push,
  output logic      full,
  input  mphp_in_t  in_data_i,
  input  logic      pop,
  output logic      empty,
  output mphp_out_t out_data_o
);

  logic      accept;
  logic      cmd_push;
  mphp_cmd_t cmd_wr;
  logic      cmd_pop;
  mphp_cmd_t cmd_rd;
  logic      cmd_empty;

  // Byte accepted: front updates its position state on this edge.
  assign accept = push && !full;

  // Front: start code check, syntax detection, stuffing count-down.
  mphp_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .in_data_i  (in_data_i),
    .cmd_push_o (cmd_push),
    .cmd_o      (cmd_wr)
  );

  // Short queue so the front keeps running while a result waits.
  mphp_cmd_fifo u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (cmd_push),
    .wr_data_i (cmd_wr),
    .full_o    (full),
    .rd_en_i   (cmd_pop),
    .rd_data_o (cmd_rd),
    .empty_o   (cmd_empty)
  );

  // Back: header byte store, field assembly, result register.
  mphp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_empty_i (cmd_empty),
    .cmd_i       (cmd_rd),
    .cmd_pop_o   (cmd_pop),
    .pop         (pop),
    .empty       (empty),
    .out_data_o  (out_data_o)
  );

endmodule

@@ sv/mphp_checker.sv @@
// Port-level checks of the pack header parser, bound to the top level.
`include "mpeg_pack_header_parser_top_assert.svh"

module mphp_checker
  import mphp_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      full,
  input logic      pop,
  input logic      empty,
  input mphp_out_t out_data_o
);

  logic bad_shown, bad_rest_zero;
  logic m1_shown, m1_rest_zero;

  assign bad_shown     = !empty && out_data_o.bad_start;
  assign bad_rest_zero = !out_data_o.is_mpeg2 && out_data_o.clock_ref_base == '0 &&
                         out_data_o.clock_ref_ext == '0 && out_data_o.mux_rate == '0 &&
                         out_data_o.stuffing_count == '0;
  assign m1_shown      = !empty && !out_data_o.bad_start && !out_data_o.is_mpeg2;
  assign m1_rest_zero  = out_data_o.clock_ref_ext == '0 && out_data_o.stuffing_count == '0;

  // Error results carry nothing but the flag.
  `MPHP_ASSERT_IMP(a_bad_clean, clk_i, rst_ni, bad_shown, bad_rest_zero)

  // MPEG-1 results have no extension and no stuffing.
  `MPHP_ASSERT_IMP(a_m1_fields, clk_i, rst_ni, m1_shown, m1_rest_zero)

  // A waiting result stays put until popped.
  `MPHP_ASSERT(a_hold, clk_i, rst_ni, (!empty && !pop) |=> (!empty && $stable(out_data_o)))

  // The input only backs up behind a waiting result.
  `MPHP_ASSERT_IMP(a_full_held, clk_i, rst_ni, full, !empty)

endmodule

bind mpeg_pack_header_parser_top mphp_checker u_mphp_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .full       (full),
  .pop        (pop),
  .empty      (empty),
  .out_data_o (out_data_o)
);
